>>> rtl/brainfuck_instruction_executor_defines.svh
// Assertion macros shared by the executor's RTL modules.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef BRAINFUCK_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define BRAINFUCK_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BFIE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BFIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bfie_pkg.sv
// Shared types, codes and constants of the instruction executor.
// No dependencies; the sequencer, the datapath and the top level import this package.
package bfie_pkg;

  localparam int DEF_TAPE_CELLS    = 30000;
  localparam int DEF_PROGRAM_DEPTH = 4096;

  localparam int CMD_W       = 2;
  localparam int PROG_ADDR_W = 12;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int PC_NOW_W    = 13;
  localparam int PTR_NOW_W   = 15;
  localparam int LEN_W       = 13;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 2'd3;

  localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] OP_JZ    = 8'h5B;
  localparam logic [BYTE_W-1:0] OP_JNZ   = 8'h5D;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [PROG_ADDR_W-1:0] prog_addr;
    logic [BYTE_W-1:0]      prog_byte;
    logic [BYTE_W-1:0]      in_byte;
    logic                   in_eof;
  } in_word_t;

  typedef struct packed {
    logic                 out_valid;
    logic [BYTE_W-1:0]    out_byte;
    logic [STATUS_W-1:0]  status;
    logic [PC_NOW_W-1:0]  pc_now;
    logic [PTR_NOW_W-1:0] pointer_now;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic clr_run;
    logic exec;
    logic scan;
    logic load_res;
  } ctl_cmd_t;

  typedef struct packed {
    logic halted;
    logic clr_last;
    logic start_scan;
    logic scan_end;
  } dp_stat_t;

endpackage

>>> rtl/bfie_chan_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// No dependencies; the payload type is given at instantiation.
interface bfie_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bfie_ctrl.sv
// Sequencer of the executor: input and output handshakes and command issue.
// Depends on bfie_pkg and the assertion macros.
`include "brainfuck_instruction_executor_defines.svh"

module bfie_ctrl import bfie_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output ctl_cmd_t         cmd,
  input  dp_stat_t         stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       clr_resp_r, clr_resp_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    clr_resp_nxt  = clr_resp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (stat.clr_last) begin
          state_nxt    = clr_resp_r ? S_RESP : S_IDLE;
          clr_resp_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_cmd)
            CMD_CLEAR: begin
              state_nxt    = S_CLEAR;
              clr_resp_nxt = 1'b1;
            end
            CMD_STEP: begin
              state_nxt = stat.halted ? S_RESP : S_EXEC;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.start_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_res  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `BFIE_ASSERT_NEXT(a_scan_to_resp, (state_r == S_SCAN) && stat.scan_end, state_r == S_RESP, "Scan end did not lead to the response state.")
  `BFIE_ASSERT(a_word_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP, "Output word raised outside the response state.")
  `BFIE_ASSERT_NEXT(a_sweep_holds, (state_r == S_CLEAR) && !stat.clr_last, state_r == S_CLEAR, "Tape sweep left before its last cell.")

endmodule

>>> rtl/bfie_dpath.sv
// Datapath of the executor: program store, tape, pointer, program counter,
// bracket scan and result register. Depends on bfie_pkg and the macros.
`include "brainfuck_instruction_executor_defines.svh"

module bfie_dpath import bfie_pkg::*; #(
  parameter int TAPE_CELLS    = DEF_TAPE_CELLS,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  in_word_t         in_word,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  output out_word_t        res
);

  localparam int PTR_W = $clog2(TAPE_CELLS);
  localparam int PA_W  = $clog2(PROGRAM_DEPTH);
  localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);
  localparam logic [PC_W-1:0]  PROG_END  = PC_W'(PROGRAM_DEPTH);
  localparam logic [PC_W-1:0]  PC_ONE    = PC_W'(1);

  logic [BYTE_W-1:0] prog_mem [PROGRAM_DEPTH];
  logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];

  logic [LEN_W-1:0]    len_r;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [PTR_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [PC_W-1:0]     depth_r, depth_nxt;
  logic [PC_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic                scan_bwd_r, scan_bwd_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic                emit_r, emit_nxt;
  logic [BYTE_W-1:0]   ebyte_r, ebyte_nxt;
  logic [BYTE_W-1:0]   wr_byte_r, wr_byte_nxt;
  logic [BYTE_W-1:0]   prog_rd_r;
  logic [BYTE_W-1:0]   tape_rd_r;
  out_word_t           res_r;

  logic [31:0]       len_ext, addr_ext, pc_ext, ptr_ext;
  logic [PC_W-1:0]   eff_len, pc_inc, pc_dec, scan_inc, scan_dec, scan_next;
  logic              halted, deeper, shallower;
  logic [PA_W-1:0]   prog_raddr;
  logic              prog_we;
  logic              tape_we;
  logic [PTR_W-1:0]  tape_waddr;
  logic [BYTE_W-1:0] tape_wdata;

  assign len_ext   = 32'(len_r);
  assign addr_ext  = 32'(in_word.prog_addr);
  assign pc_ext    = 32'(pc_r);
  assign ptr_ext   = 32'(ptr_r);
  assign eff_len   = (len_ext > 32'(PROGRAM_DEPTH)) ? PROG_END : PC_W'(len_ext);
  assign halted    = (pc_r >= eff_len);
  assign pc_inc    = pc_r + PC_ONE;
  assign pc_dec    = pc_r - PC_ONE;
  assign scan_inc  = scan_addr_r + PC_ONE;
  assign scan_dec  = scan_addr_r - PC_ONE;
  assign scan_next = scan_bwd_r ? scan_dec : scan_inc;
  assign deeper    = scan_bwd_r ? (prog_rd_r == OP_JNZ) : (prog_rd_r == OP_JZ);
  assign shallower = scan_bwd_r ? (prog_rd_r == OP_JZ) : (prog_rd_r == OP_JNZ);

  always_comb begin
    pc_nxt        = pc_r;
    ptr_nxt       = ptr_r;
    clr_idx_nxt   = clr_idx_r;
    depth_nxt     = depth_r;
    scan_addr_nxt = scan_addr_r;
    scan_bwd_nxt  = scan_bwd_r;
    st_nxt        = st_r;
    emit_nxt      = emit_r;
    ebyte_nxt     = ebyte_r;
    wr_byte_nxt   = wr_byte_r;
    prog_raddr    = pc_r[PA_W-1:0];
    prog_we       = 1'b0;
    tape_we       = 1'b0;
    tape_waddr    = ptr_r;
    tape_wdata    = '0;
    stat          = '0;
    stat.halted   = halted;
    stat.clr_last = (clr_idx_r == LAST_CELL);

    if (cmd.accept) begin
      st_nxt      = ST_OK;
      emit_nxt    = 1'b0;
      ebyte_nxt   = '0;
      wr_byte_nxt = in_word.in_eof ? '0 : in_word.in_byte;
      case (in_word.cmd)
        CMD_LOAD: begin
          prog_we = (addr_ext < 32'(PROGRAM_DEPTH));
        end
        CMD_CLEAR: begin
          pc_nxt      = '0;
          ptr_nxt     = '0;
          clr_idx_nxt = '0;
        end
        CMD_STEP: begin
          if (halted) begin
            st_nxt = ST_HALTED;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.clr_run) begin
      tape_we     = 1'b1;
      tape_waddr  = clr_idx_r;
      clr_idx_nxt = stat.clr_last ? '0 : clr_idx_r + PTR_W'(1);
    end

    if (cmd.exec) begin
      pc_nxt = pc_inc;
      case (prog_rd_r)
        OP_INC: begin
          tape_we    = 1'b1;
          tape_wdata = tape_rd_r + BYTE_W'(1);
        end
        OP_DEC: begin
          tape_we    = 1'b1;
          tape_wdata = tape_rd_r - BYTE_W'(1);
        end
        OP_RIGHT: begin
          ptr_nxt = (ptr_r == LAST_CELL) ? '0 : ptr_r + PTR_W'(1);
        end
        OP_LEFT: begin
          ptr_nxt = (ptr_r == '0) ? LAST_CELL : ptr_r - PTR_W'(1);
        end
        OP_IN: begin
          tape_we    = 1'b1;
          tape_wdata = wr_byte_r;
        end
        OP_OUT: begin
          emit_nxt  = 1'b1;
          ebyte_nxt = tape_rd_r;
        end
        OP_JZ: begin
          if (tape_rd_r == '0) begin
            pc_nxt = pc_r;
            if (pc_inc >= eff_len) begin
              st_nxt = ST_UNMATCHED;
            end else begin
              stat.start_scan = 1'b1;
              scan_addr_nxt   = pc_inc;
              scan_bwd_nxt    = 1'b0;
              depth_nxt       = PC_ONE;
              prog_raddr      = pc_inc[PA_W-1:0];
            end
          end
        end
        OP_JNZ: begin
          if (tape_rd_r != '0) begin
            pc_nxt = pc_r;
            if (pc_r == '0) begin
              st_nxt = ST_UNMATCHED;
            end else begin
              stat.start_scan = 1'b1;
              scan_addr_nxt   = pc_dec;
              scan_bwd_nxt    = 1'b1;
              depth_nxt       = PC_ONE;
              prog_raddr      = pc_dec[PA_W-1:0];
            end
          end
        end
        default: begin
          st_nxt = ST_UNKNOWN;
        end
      endcase
    end

    // The byte at scan_addr_r is in prog_rd_r; the next address is read meanwhile.
    if (cmd.scan) begin
      if (shallower && (depth_r == PC_ONE)) begin
        pc_nxt        = scan_inc;
        depth_nxt     = '0;
        stat.scan_end = 1'b1;
      end else if (scan_bwd_r ? (scan_addr_r == '0) : (scan_inc >= eff_len)) begin
        st_nxt        = ST_UNMATCHED;
        depth_nxt     = '0;
        stat.scan_end = 1'b1;
      end else begin
        if (deeper) begin
          depth_nxt = depth_r + PC_ONE;
        end else if (shallower) begin
          depth_nxt = depth_r - PC_ONE;
        end
        scan_addr_nxt = scan_next;
        prog_raddr    = scan_next[PA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[addr_ext[PA_W-1:0]] <= in_word.prog_byte;
    end
    prog_rd_r <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    tape_rd_r <= tape_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      pc_r      <= '0;
      ptr_r     <= '0;
      clr_idx_r <= '0;
      depth_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      pc_r      <= pc_nxt;
      ptr_r     <= ptr_nxt;
      clr_idx_r <= clr_idx_nxt;
      depth_r   <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    scan_bwd_r  <= scan_bwd_nxt;
    st_r        <= st_nxt;
    emit_r      <= emit_nxt;
    ebyte_r     <= ebyte_nxt;
    wr_byte_r   <= wr_byte_nxt;
    if (cmd.load_res) begin
      res_r.out_valid   <= emit_r;
      res_r.out_byte    <= ebyte_r;
      res_r.status      <= st_r;
      res_r.pc_now      <= pc_ext[PC_NOW_W-1:0];
      res_r.pointer_now <= ptr_ext[PTR_NOW_W-1:0];
    end
  end

  assign res = res_r;

  `BFIE_ASSERT(a_ptr_range, 1'b1, ptr_r <= LAST_CELL, "Data pointer left the tape.")
  `BFIE_ASSERT(a_pc_range, 1'b1, pc_r <= PROG_END, "Program counter beyond the program store.")
  `BFIE_ASSERT(a_scan_depth, cmd.scan, depth_r != '0, "Bracket scan running at zero depth.")
  `BFIE_ASSERT_NEXT(a_sweep_wrap, cmd.clr_run && stat.clr_last, clr_idx_r == '0, "Sweep index did not return to zero.")

endmodule

>>> rtl/brainfuck_instruction_executor.sv
// Top level of the instruction executor: sequencer plus datapath.
// Depends on bfie_pkg, bfie_chan_if, bfie_ctrl and bfie_dpath.
//
// Usage. Words arrive on in_ch (valid/ready) and each gives exactly one word on
// out_ch. A load word writes one program byte, a step word executes the
// instruction at the program counter, and a clear word zeroes the tape and
// resets the pointer and the program counter. cfg_wr_en with cfg_wr_data sets
// the program length; write it only while no word is in flight.
// Sequence. Load and unused words, and a step at a halted program, go from
// acceptance straight to the output register; a step first reads the program
// byte and the tape cell, then does the read-modify-write of the cell. A
// bracket jump then walks the program store, one byte a cycle, to its match.
// A clear word sweeps the tape one cell a cycle, all TAPE_CELLS cells, before
// its result. After reset the same sweep runs and in_ch.ready stays low until
// it ends; configuration writes are taken throughout.
// One word is worked on at a time. The result waits in the output register
// while the receiver stalls; the next word is accepted meanwhile and its result
// is held back until the register is free.
module brainfuck_instruction_executor import bfie_pkg::*; #(
  parameter int TAPE_CELLS    = DEF_TAPE_CELLS,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  bfie_chan_if.sink         in_ch,
  bfie_chan_if.source       out_ch,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data
);

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  out_word_t res;
  in_word_t  in_word;

  assign in_word     = in_ch.data;
  assign out_ch.data = res;

  bfie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_word.cmd),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  bfie_dpath #(
    .TAPE_CELLS    (TAPE_CELLS),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .cmd         (cmd),
    .stat        (stat),
    .res         (res)
  );

endmodule
